// ===== rtl/grid_path_count_with_obstacles_defines.svh =====
// ----------------------------------------------------------------------------
// Grid path counter assertion macros
// Shared assertion macros for the grid path counter checkers.
// ----------------------------------------------------------------------------
`ifndef GRID_PATH_COUNT_WITH_OBSTACLES_DEFINES_SVH
`define GRID_PATH_COUNT_WITH_OBSTACLES_DEFINES_SVH

// Same-cycle implication.
`define GPC_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GPC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid path counter package
// Constants and default sizes shared by the grid path counter modules.
// ----------------------------------------------------------------------------
package gpc_pkg;

   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLS    = 64;
   localparam int DEF_COUNT_WIDTH = 32;

   localparam int SIZE_WIDTH  = 7;
   localparam int PATH_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH = 1;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_NUM_ROWS = 1'b0,
      CSR_NUM_COLS = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/gpc_cell.sv =====
// ----------------------------------------------------------------------------
// Grid path counter row cell
// Holds one path count of the row above and passes it on towards the head
// of the chain on every accepted transaction.
// ----------------------------------------------------------------------------
module gpc_cell #(
   parameter int WIDTH = gpc_pkg::DEF_COUNT_WIDTH
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic             load_new,
   input  logic [WIDTH-1:0] new_count,
   input  logic [WIDTH-1:0] next_count,
   output logic [WIDTH-1:0] count
);

   logic [WIDTH-1:0] count_ff;
   logic [WIDTH-1:0] count_in;

   assign count_in = load_new ? new_count : next_count;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ===== rtl/gpc_row_chain.sv =====
// ----------------------------------------------------------------------------
// Grid path counter row chain
// A chain of count cells that acts as a shift line whose length follows the
// number of columns in use; the head cell always holds the count above.
// ----------------------------------------------------------------------------
module gpc_row_chain #(
   parameter int DEPTH     = gpc_pkg::DEF_MAX_COLS,
   parameter int WIDTH     = gpc_pkg::DEF_COUNT_WIDTH,
   parameter int IDX_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 shift_en,
   input  logic [IDX_WIDTH-1:0] last_idx,
   input  logic [WIDTH-1:0]     new_count,
   output logic [WIDTH-1:0]     head_count
);

   logic [WIDTH-1:0] cell_count [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] next_count;

      if (i == DEPTH - 1) begin : g_tail
         assign next_count = '0;
      end else begin : g_body
         assign next_count = cell_count[i+1];
      end

      gpc_cell #(
         .WIDTH (WIDTH)
      ) u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .load_new   (last_idx == IDX_WIDTH'(i)),
         .new_count  (new_count),
         .next_count (next_count),
         .count      (cell_count[i])
      );
   end

   assign head_count = cell_count[0];

endmodule

// ===== rtl/grid_path_count_with_obstacles.sv =====
// ----------------------------------------------------------------------------
// Grid path counter with obstacles
// Counts the right/down paths across a grid whose cells arrive in row-major
// order, one obstacle bit per transaction.
// ----------------------------------------------------------------------------
// One cell is taken in every cycle unless the input stalls, and the result
// of a grid is registered as its last cell is accepted. The counts of the
// row above live in a chain of MAX_COLS cells that shifts once per accepted
// cell, so the count above is always at the head of the chain. The input
// stalls only on the last cell of a grid while the previous result is still
// waiting to be taken. Writing either size register rewinds the grid.
module grid_path_count_with_obstacles #(
   parameter int MAX_ROWS    = gpc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS    = gpc_pkg::DEF_MAX_COLS,
   parameter int COUNT_WIDTH = gpc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [gpc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [gpc_pkg::SIZE_WIDTH-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_blocked,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gpc_pkg::PATH_WIDTH-1:0]      rsp_path_count,
   output logic                                rsp_saturated
);

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [RW-1:0]          last_row_ff, last_row_in;
   logic [CW-1:0]          last_col_ff, last_col_in;
   logic [RW-1:0]          row_ff, row_in;
   logic [CW-1:0]          col_ff, col_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [gpc_pkg::PATH_WIDTH-1:0] path_ff, path_in;
   logic                   sat_ff, sat_in;

   logic                   req_accept;
   logic                   at_last_col;
   logic                   at_last_row;
   logic                   at_last_cell;
   logic [COUNT_WIDTH-1:0] head_count;
   logic [COUNT_WIDTH-1:0] above;
   logic [COUNT_WIDTH-1:0] left;
   logic [COUNT_WIDTH:0]   sum;
   logic                   sum_sat;
   logic                   step_ovf;
   logic [COUNT_WIDTH-1:0] cell_value;

   assign at_last_col  = (col_ff == last_col_ff);
   assign at_last_row  = (row_ff == last_row_ff);
   assign at_last_cell = at_last_col && at_last_row;

   assign req_stall  = rsp_valid_ff && rsp_stall && at_last_cell;
   assign req_accept = req_valid && !req_stall;

   assign above   = (row_ff == '0) ? '0 : head_count;
   assign left    = (col_ff == '0) ? '0 : left_ff;
   assign sum     = {1'b0, above} + {1'b0, left};
   assign sum_sat = sum[COUNT_WIDTH];

   always_comb begin
      step_ovf = 1'b0;
      priority if (req_blocked) begin
         cell_value = '0;
      end else if ((row_ff == '0) && (col_ff == '0)) begin
         cell_value = COUNT_WIDTH'(1);
      end else if (sum_sat) begin
         cell_value = '1;
         step_ovf   = 1'b1;
      end else begin
         cell_value = sum[COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      if (csr_write_en) begin
         unique case (gpc_pkg::csr_index_type'(csr_index))
            gpc_pkg::CSR_NUM_ROWS: begin
               priority if (csr_wdata == '0) begin
                  last_row_in = '0;
               end else if (int'(csr_wdata) > MAX_ROWS) begin
                  last_row_in = RW'(MAX_ROWS - 1);
               end else begin
                  last_row_in = RW'(csr_wdata - 7'd1);
               end
            end
            gpc_pkg::CSR_NUM_COLS: begin
               priority if (csr_wdata == '0) begin
                  last_col_in = '0;
               end else if (int'(csr_wdata) > MAX_COLS) begin
                  last_col_in = CW'(MAX_COLS - 1);
               end else begin
                  last_col_in = CW'(csr_wdata - 7'd1);
               end
            end
            default: begin
               last_row_in = last_row_ff;
            end
         endcase
      end
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      left_in      = left_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      path_in      = path_ff;
      sat_in       = sat_ff;
      priority if (csr_write_en) begin
         row_in  = '0;
         col_in  = '0;
         left_in = '0;
         ovf_in  = 1'b0;
      end else if (req_accept) begin
         priority if (!at_last_col) begin
            col_in  = col_ff + CW'(1);
            left_in = cell_value;
            ovf_in  = ovf_ff || step_ovf;
         end else if (!at_last_row) begin
            col_in  = '0;
            row_in  = row_ff + RW'(1);
            left_in = '0;
            ovf_in  = ovf_ff || step_ovf;
         end else begin
            row_in       = '0;
            col_in       = '0;
            left_in      = '0;
            ovf_in       = 1'b0;
            rsp_valid_in = 1'b1;
            path_in      = gpc_pkg::PATH_WIDTH'(cell_value);
            sat_in       = ovf_ff || step_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff  <= '0;
         last_col_ff  <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         left_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_row_ff  <= last_row_in;
         last_col_ff  <= last_col_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         left_ff      <= left_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      path_ff <= path_in;
      sat_ff  <= sat_in;
   end

   gpc_row_chain #(
      .DEPTH     (MAX_COLS),
      .WIDTH     (COUNT_WIDTH),
      .IDX_WIDTH (CW)
   ) u_row_chain (
      .clock      (clock),
      .shift_en   (req_accept && !csr_write_en),
      .last_idx   (last_col_ff),
      .new_count  (cell_value),
      .head_count (head_count)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = path_ff;
   assign rsp_saturated  = sat_ff;

endmodule

// ===== rtl/gpc_checker.sv =====
// ----------------------------------------------------------------------------
// Grid path counter checker
// Port-level assertions for the grid path counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_path_count_with_obstacles_defines.svh"

module gpc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [gpc_pkg::PATH_WIDTH-1:0]    rsp_path_count,
   input logic                              rsp_saturated
);

   `GPC_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid,
      "result transaction dropped while stalled")

   `GPC_ASSERT_NEXT(a_rsp_payload_holds, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_path_count) && $stable(rsp_saturated),
      "stalled result payload changed")

   `GPC_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid,
      "result valid after reset")

   `GPC_ASSERT_IMPLIES(a_rsp_needs_req, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall),
      "result without an accepted request transaction")

endmodule

bind grid_path_count_with_obstacles gpc_checker u_gpc_checker (.*);
